/* hw/rtl/stwq_pkg.sv */
// Shared types and constants for the sleep timer wake queue.
// No dependencies; the interfaces, the controller and the top level use this package, the slot memory does not.
package stwq_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int ID_BITS_DEF = 8;

	// Fixed field widths of the request and response words
	localparam int TICK_W  = 64;
	localparam int TID_W   = 8;
	localparam int TICKS_W = 32;

	typedef enum logic {
		CMD_SLEEP = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_WOKEN  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_SCAN
	} state_t;

endpackage

/* hw/rtl/stwq_ifs.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on stwq_pkg for the command and result kind types.
interface stwq_req_if;
	logic                                valid;
	logic                                ready;
	stwq_pkg::cmd_t                      command;
	logic [stwq_pkg::TID_W-1:0]          thread_id;
	logic [stwq_pkg::TICKS_W-1:0]        sleep_ticks;

	modport source (output valid, command, thread_id, sleep_ticks, input ready);
	modport sink (input valid, command, thread_id, sleep_ticks, output ready);
endinterface

interface stwq_rsp_if;
	logic                                valid;
	logic                                ready;
	stwq_pkg::kind_t                     kind;
	logic [stwq_pkg::TID_W-1:0]          woken_id;
	logic                                last;

	modport source (output valid, kind, woken_id, last, input ready);
	modport sink (input valid, kind, woken_id, last, output ready);
endinterface

/* hw/rtl/stwq_slot_ram.sv */
// Slot table memory: one write port, one read port, registered read data.
// Holds thread id and absolute wake time per slot. No package dependency.
module stwq_slot_ram #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold read data when no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/stwq_ctrl.sv */
// Sequencer of the wake queue: tick counter, slot valid bits, free-slot search,
// expiry scan over the slot memory and the response register. Uses stwq_pkg.
module stwq_ctrl #(
	parameter int SLOTS   = stwq_pkg::SLOTS_DEF,
	parameter int ID_BITS = stwq_pkg::ID_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	stwq_req_if.sink                             req,
	stwq_rsp_if.source                           rsp,
	output logic                                 mem_we,
	output logic                                 mem_re,
	output logic [$clog2(SLOTS)-1:0]             mem_addr,
	output logic [ID_BITS+stwq_pkg::TICK_W-1:0]  mem_wdata,
	input  logic [ID_BITS+stwq_pkg::TICK_W-1:0]  mem_rdata
);
	import stwq_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	state_t              state_q, state_d;
	logic [IDX_W-1:0]    idx_q;
	logic                rd_done_q;
	logic                chk_v_s1;
	logic [IDX_W-1:0]    chk_idx_s1;
	logic                pend_v_q;
	logic [ID_BITS-1:0]  pend_id_q;
	logic [SLOTS-1:0]    valid_q;
	logic [TICK_W-1:0]   count_q;
	logic [ID_BITS-1:0]  id_q;
	logic [TICK_W-1:0]   wake_q;
	logic                out_v_q;
	kind_t               out_kind_q;
	logic [TID_W-1:0]    out_id_q;
	logic                out_last_q;

	logic                can_push, hit, stall, take;
	logic                push, push_last, set_valid, clr_valid, s1_load, idx_inc;
	kind_t               push_kind;
	logic [ID_BITS-1:0]  push_id;
	logic [ID_BITS-1:0]  rd_id;
	logic [TICK_W-1:0]   rd_wake;

	assign rd_id    = mem_rdata[TICK_W +: ID_BITS];
	assign rd_wake  = mem_rdata[TICK_W-1:0];
	assign can_push = !out_v_q || rsp.ready;
	// Slot memory is only written during a search, never during a scan: no forwarding
	assign hit      = chk_v_s1 && valid_q[chk_idx_s1] && (rd_wake <= count_q);
	// A second hit must first move the held thread id out
	assign stall    = hit && pend_v_q && !can_push;

	assign req.ready    = (state_q == ST_IDLE);
	assign mem_addr     = idx_q;
	assign mem_wdata    = {id_q, wake_q};
	assign rsp.valid    = out_v_q;
	assign rsp.kind     = out_kind_q;
	assign rsp.woken_id = out_id_q;
	assign rsp.last     = out_last_q;

	always_comb begin
		state_d   = state_q;
		take      = 1'b0;
		push      = 1'b0;
		push_kind = KIND_WOKEN;
		push_id   = pend_id_q;
		push_last = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		s1_load   = 1'b0;
		idx_inc   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				take = req.valid;
				if (req.valid) begin
					state_d = (req.command == CMD_SLEEP) ? ST_FIND : ST_SCAN;
				end
			end
			ST_FIND: begin
				push_id   = id_q;
				push_last = 1'b1;
				if (!valid_q[idx_q]) begin
					push_kind = KIND_ACCEPT;
					if (can_push) begin
						push      = 1'b1;
						mem_we    = 1'b1;
						set_valid = 1'b1;
						state_d   = ST_IDLE;
					end
				end else if (idx_q == LAST_IDX) begin
					push_kind = KIND_REJECT;
					if (can_push) begin
						push    = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					s1_load   = 1'b1;
					mem_re    = !rd_done_q;
					idx_inc   = !rd_done_q && (idx_q != LAST_IDX);
					clr_valid = hit;
					if (hit && pend_v_q) begin
						push = 1'b1;
					end
					if (rd_done_q && !chk_v_s1) begin
						if (!pend_v_q) begin
							state_d = ST_IDLE;
						end else if (can_push) begin
							push      = 1'b1;
							push_last = 1'b1;
							state_d   = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			rd_done_q <= 1'b0;
			chk_v_s1  <= 1'b0;
			pend_v_q  <= 1'b0;
			valid_q   <= '0;
			count_q   <= '0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				idx_q     <= '0;
				rd_done_q <= 1'b0;
				chk_v_s1  <= 1'b0;
				pend_v_q  <= 1'b0;
				if (req.command == CMD_TICK) begin
					count_q <= count_q + TICK_W'(1);
				end
			end else begin
				if (idx_inc) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (s1_load) begin
					chk_v_s1 <= mem_re;
					if (mem_re && idx_q == LAST_IDX) begin
						rd_done_q <= 1'b1;
					end
					if (hit) begin
						pend_v_q <= 1'b1;
					end
				end
			end
			if (set_valid) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[chk_idx_s1] <= 1'b0;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			id_q   <= ID_BITS'(req.thread_id);
			wake_q <= count_q + TICK_W'(req.sleep_ticks);
		end
		if (s1_load) begin
			chk_idx_s1 <= idx_q;
		end
		if (s1_load && hit) begin
			pend_id_q <= rd_id;
		end
		if (push) begin
			out_kind_q <= push_kind;
			out_id_q   <= TID_W'(push_id);
			out_last_q <= push_last;
		end
	end

endmodule

/* hw/rtl/sleep_timer_wake_queue.sv */
// Sleep timer wake queue: a 64-bit tick counter and a SLOTS-entry table of sleeping thread
// ids with absolute wake times, kept in a one-port-write, one-port-read slot memory. A sleep
// request takes the lowest free slot and answers accepted, or rejected when the table is full;
// the free-slot search visits one valid bit per cycle. A tick advances the counter
// and reads every slot once through the memory, one slot per cycle while the scan is
// not stalled, with registered read data; each expired slot gives one woken word in
// slot order, the final one marked last, and a tick with no expiry gives none. A full
// response register stalls the scan. No clearing pass after reset.
module sleep_timer_wake_queue #(
	parameter int SLOTS   = stwq_pkg::SLOTS_DEF,
	parameter int ID_BITS = stwq_pkg::ID_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	stwq_req_if.sink     req,
	stwq_rsp_if.source   rsp
);
	import stwq_pkg::*;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int DATA_W = ID_BITS + TICK_W;

	logic              mem_we;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_addr;
	logic [DATA_W-1:0] mem_wdata;
	logic [DATA_W-1:0] mem_rdata;

	stwq_ctrl #(
		.SLOTS   (SLOTS),
		.ID_BITS (ID_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	stwq_slot_ram #(
		.DEPTH  (SLOTS),
		.DATA_W (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

endmodule
